>>> rtl/lkc_pkg.sv
// Package for line_k_center_min_radius: widths, sequencer states and the
// request/response types of the shared add/subtract/compare unit.
// No dependencies.
`default_nettype none

package lkc_pkg;

    localparam int GAP_W   = 32;   // input gap width
    localparam int POS_W   = 42;   // point position and radius width
    localparam int CFG_W   = 11;   // max_centers register width
    localparam int OUT_W   = 48;   // result tdata width (POS_W rounded up to bytes)

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_MID_DIFF,
        ST_MID_ADD,
        ST_FETCH,
        ST_TEST,
        ST_DECIDE,
        ST_STEP_LOW,
        ST_DONE
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [POS_W-1:0]   a;
        logic [POS_W-1:0]   b;
        logic [POS_W-1:0]   lim;
    } alu_req_t;

    typedef struct packed {
        logic [POS_W:0]     sum;   // carry out in the top bit on add
        logic               le;    // low POS_W bits of the result <= lim
    } alu_rsp_t;

endpackage

`default_nettype wire

>>> rtl/lkc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lkc_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(DEPTH)-1:0]     waddr,
    input  wire logic [WIDTH-1:0]             wdata,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr,
    output logic      [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/lkc_alu.sv
// Shared arithmetic unit: one wide add or subtract followed by a compare
// against a limit. Depends on lkc_pkg.
`default_nettype none

module lkc_alu (
    input  wire lkc_pkg::alu_req_t  req,
    output lkc_pkg::alu_rsp_t       rsp
);

    import lkc_pkg::*;

    logic [POS_W:0] sum;

    always_comb
    begin
        case (req.op)
            ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
            default: sum = '0;
        endcase
    end

    assign rsp.sum = sum;
    assign rsp.le  = (sum[POS_W-1:0] <= req.lim);

endmodule

`default_nettype wire

>>> rtl/line_k_center_min_radius.sv
// line_k_center_min_radius: top level. Loads gaps, then binary-searches the
// smallest covering radius. Depends on lkc_pkg, lkc_alu and lkc_ram.
`default_nettype none

// Gaps arrive on the slave stream, one beat per cycle, and are turned into
// point positions (running sums from zero, saturating at 2^42-1) stored in a
// RAM of MAX_POINTS entries; once the RAM is full further gaps are dropped.
// A beat with s_tlast high closes the list and starts the search: the block
// drops s_tready and binary-searches the radius d in [0, last position].
// Each probe walks the stored points in order with a greedy cover (a center
// sits on the farthest point within d of a group's first point, and the
// group extends to every point within d of that center) and counts centers
// against max_centers. One shared add/subtract/compare unit does every
// running sum, midpoint, distance test and bound update, so the search costs
// about ceil(log2(span+1)) probes. Each probe reads the stored points after
// the first in turn (one RAM read per point, plus a second test on the same
// point when a group switches from its first point to its center) and does
// its bookkeeping (bound check, midpoint difference, midpoint sum, decision,
// and a low-bound step when the probe does not fit). The result leaves on
// m_tdata through an output register; the next list may start loading while
// it waits to be taken.
// After a result the point list is back to one point at zero; max_centers
// (written through cfg_wr_en/cfg_wr_data while idle, reset value 1) keeps
// its value. A max_centers of zero yields the full span.

module line_k_center_min_radius #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // configuration: max_centers
    input  wire logic           cfg_wr_en,
    input  wire logic [10:0]    cfg_wr_data,
    // slave stream
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [31:0]    s_tdata,    // [31:0] gap
    input  wire logic           s_tlast,    // last_gap
    // master stream
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic      [47:0]    m_tdata     // [41:0] min_radius, [47:42] zero
);

    import lkc_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // sequencer
    state_t             state_reg, state_next;

    // list and search state
    logic [CFG_W-1:0]   max_centers_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]   last_pos_reg, last_pos_next;
    logic [POS_W-1:0]   low_reg, low_next;
    logic [POS_W-1:0]   high_reg, high_next;
    logic [POS_W-1:0]   half_reg, half_next;
    logic [POS_W-1:0]   mid_reg, mid_next;

    // cover walk state
    logic [AW-1:0]      j_reg, j_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [POS_W-1:0]   cen_reg, cen_next;
    logic               phase_b_reg, phase_b_next;
    logic [CNT_W-1:0]   used_reg, used_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   out_reg, out_next;

    // shared unit and memory
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;
    logic               mem_we;
    logic [POS_W-1:0]   mem_q;

    // status
    logic               accept;
    logic               not_full;
    logic [POS_W-1:0]   new_pos;
    logic               pass_last;
    logic               fits;
    logic               out_free;
    logic               single_point;

    lkc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    lkc_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (new_pos),
        .raddr (j_reg),
        .rdata (mem_q)
    );

    assign accept       = s_tvalid && s_tready;
    assign not_full     = (count_reg < CNT_W'(MAX_POINTS));
    assign new_pos      = alu_rsp.sum[POS_W] ? {POS_W{1'b1}} : alu_rsp.sum[POS_W-1:0];
    assign pass_last    = (({1'b0, j_reg} + (AW+1)'(1)) == (AW+1)'(count_reg));
    assign fits         = (CMP_W'(used_reg) <= CMP_W'(max_centers_reg));
    assign out_free     = !out_valid_reg || m_tready;
    assign single_point = (count_reg == CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && s_tlast)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:    state_next = (low_reg == high_reg) ? ST_DONE : ST_MID_DIFF;
            ST_MID_DIFF: state_next = ST_MID_ADD;
            ST_MID_ADD:  state_next = single_point ? ST_DECIDE : ST_FETCH;
            ST_FETCH:    state_next = ST_TEST;
            ST_TEST:
            begin
                // a first-point miss retests the same point against the center
                if (!alu_rsp.le && !phase_b_reg)
                begin
                    state_next = ST_TEST;
                end
                else if (pass_last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_DECIDE:   state_next = fits ? ST_CHECK : ST_STEP_LOW;
            ST_STEP_LOW: state_next = ST_CHECK;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        last_pos_next  = last_pos_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        half_next      = half_reg;
        mid_next       = mid_reg;
        j_next         = j_reg;
        start_next     = start_reg;
        cen_next       = cen_reg;
        phase_b_next   = phase_b_reg;
        used_next      = used_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_we         = 1'b0;
        alu_req.op     = ALU_ADD;
        alu_req.a      = last_pos_reg;
        alu_req.b      = POS_W'(s_tdata);
        alu_req.lim    = mid_reg;

        case (state_reg)
            ST_LOAD:
            begin
                // running sum of the incoming gap; saturate on carry
                if (accept)
                begin
                    if (not_full)
                    begin
                        mem_we        = 1'b1;
                        last_pos_next = new_pos;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    if (s_tlast)
                    begin
                        low_next  = '0;
                        high_next = not_full ? new_pos : last_pos_reg;
                    end
                end
            end
            ST_MID_DIFF:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = high_reg;
                alu_req.b  = low_reg;
                half_next  = {1'b0, alu_rsp.sum[POS_W-1:1]};
            end
            ST_MID_ADD:
            begin
                alu_req.op   = ALU_ADD;
                alu_req.a    = low_reg;
                alu_req.b    = half_reg;
                mid_next     = alu_rsp.sum[POS_W-1:0];
                // first group opens at the point at zero
                j_next       = AW'(1);
                start_next   = '0;
                cen_next     = '0;
                phase_b_next = 1'b0;
                used_next    = CNT_W'(1);
            end
            ST_TEST:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = mem_q;
                alu_req.b  = phase_b_reg ? cen_reg : start_reg;
                if (alu_rsp.le)
                begin
                    if (!phase_b_reg)
                    begin
                        cen_next = mem_q;
                    end
                    j_next = j_reg + AW'(1);
                end
                else if (!phase_b_reg)
                begin
                    phase_b_next = 1'b1;
                end
                else
                begin
                    // out of reach of the center: open a new group here
                    used_next    = used_reg + CNT_W'(1);
                    start_next   = mem_q;
                    cen_next     = mem_q;
                    phase_b_next = 1'b0;
                    j_next       = j_reg + AW'(1);
                end
            end
            ST_DECIDE:
            begin
                if (fits)
                begin
                    high_next = mid_reg;
                end
            end
            ST_STEP_LOW:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = mid_reg;
                alu_req.b  = POS_W'(1);
                low_next   = alu_rsp.sum[POS_W-1:0];
            end
            ST_DONE:
            begin
                // hand the radius over and reset the list to one point at zero
                if (out_free)
                begin
                    out_next       = low_reg;
                    out_valid_next = 1'b1;
                    count_next     = CNT_W'(1);
                    last_pos_next  = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            max_centers_reg <= CFG_W'(1);
            count_reg       <= CNT_W'(1);
            last_pos_reg    <= '0;
            low_reg         <= '0;
            high_reg        <= '0;
            j_reg           <= '0;
            start_reg       <= '0;
            cen_reg         <= '0;
            phase_b_reg     <= 1'b0;
            used_reg        <= CNT_W'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
            begin
                max_centers_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            last_pos_reg  <= last_pos_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            j_reg         <= j_next;
            start_reg     <= start_next;
            cen_reg       <= cen_next;
            phase_b_reg   <= phase_b_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        half_reg <= half_next;
        mid_reg  <= mid_next;
        out_reg  <= out_next;
    end

    // the point list always holds between one and MAX_POINTS points
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_W'(MAX_POINTS)))
        else $error("point count out of range");

    // search bounds never cross while a search is running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (low_reg <= high_reg))
        else $error("search bounds crossed");

    // a group's center never lies before its first point
    assert property (@(posedge clk) disable iff (!rst_n)
        cen_reg >= start_reg)
        else $error("center before group start");

    // centers counted in a pass never exceed the stored points
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FETCH) || (state_reg == ST_TEST) || (state_reg == ST_DECIDE))
        |-> (used_reg <= count_reg))
        else $error("center count exceeds point count");

    // a new result appears only when the search has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg ##1 out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the finish step");

endmodule

`default_nettype wire
